// File: rtl/b64e_pkg.sv
`timescale 1ns / 1ps

package b64e_pkg;

  localparam logic [6:0] PAD_CODE = 7'd61;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW = 1;

  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_ONE  = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;

  localparam logic [1:0] CHAR_LAST = 2'd3;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;
    logic       fin;
  } group_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] w;
    logic [6:0] code;
    begin
      w = {1'b0, v};
      if (v < 6'd26) begin
        code = w + 7'd65;
      end else if (v < 6'd52) begin
        code = w + 7'd71;
      end else if (v < 6'd62) begin
        code = w - 7'd4;
      end else if (v == 6'd62) begin
        code = 7'd43;
      end else begin
        code = 7'd47;
      end
      return code;
    end
  endfunction

  function automatic logic [5:0] b64_slice(input group_t g, input logic [1:0] idx);
    logic [5:0] s;
    begin
      case (idx)
        2'd0:    s = g.b0[7:2];
        2'd1:    s = {g.b0[1:0], g.b1[7:4]};
        2'd2:    s = {g.b1[3:0], g.b2[7:6]};
        default: s = g.b2[5:0];
      endcase
      return s;
    end
  endfunction

endpackage

// File: rtl/b64e_front.sv
`timescale 1ns / 1ps

module b64e_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  input  logic            q_full,
  output logic            push,
  output b64e_pkg::group_t push_group
);
  import b64e_pkg::*;

  logic [1:0] held_count;
  logic [7:0] held0;
  logic [7:0] held1;
  logic       accept;
  logic       close_group;

  assign in_ready    = !q_full;
  assign accept      = in_valid && in_ready;
  assign close_group = last_byte || (held_count == HELD_TWO);
  assign push        = accept && close_group;

  always_comb begin
    push_group.nbytes = held_count + 2'd1;
    push_group.fin    = last_byte;
    unique case (held_count)
      HELD_NONE: begin
        push_group.b0 = data_byte;
        push_group.b1 = 8'd0;
        push_group.b2 = 8'd0;
      end
      HELD_ONE: begin
        push_group.b0 = held0;
        push_group.b1 = data_byte;
        push_group.b2 = 8'd0;
      end
      default: begin
        push_group.b0 = held0;
        push_group.b1 = held1;
        push_group.b2 = data_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= HELD_NONE;
    end else if (accept) begin
      if (close_group) begin
        held_count <= HELD_NONE;
      end else begin
        held_count <= held_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !close_group) begin
      if (held_count == HELD_NONE) begin
        held0 <= data_byte;
      end else begin
        held1 <= data_byte;
      end
    end
  end

endmodule

// File: rtl/b64e_queue.sv
`timescale 1ns / 1ps

module b64e_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  b64e_pkg::group_t      push_group,
  input  logic                  pop,
  output b64e_pkg::group_t      head,
  output b64e_pkg::queue_status_t status
);
  import b64e_pkg::*;

  group_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign head         = slots[rd_ptr];
  assign status.valid = (count != '0);
  assign status.full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_group;
    end
  end

endmodule

// File: rtl/b64e_back.sv
`timescale 1ns / 1ps

module b64e_back (
  input  logic                    clk,
  input  logic                    rst,
  input  b64e_pkg::group_t        head,
  input  b64e_pkg::queue_status_t status,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [6:0]              char_code,
  output logic                    last_char
);
  import b64e_pkg::*;

  group_t     cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       done;

  assign out_valid = cur_valid;
  assign done      = cur_valid && out_ready && (idx == CHAR_LAST);
  assign pop       = status.valid && (!cur_valid || done);
  assign char_code = (idx > cur.nbytes) ? PAD_CODE : b64_char(b64_slice(cur, idx));
  assign last_char = cur.fin && (idx == CHAR_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (done) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (cur_valid && out_ready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

endmodule

// File: rtl/base64_stream_encoder.sv
`timescale 1ns / 1ps

// Base64 stream encoder with the standard alphabet and '=' padding.
// The input channel (in_valid, in_ready) carries one message byte per word in
// data_byte, with last_byte set on the final byte of a message.
// The output channel (out_valid, out_ready) carries one ASCII character per
// word in char_code, with last_char set on the final character of a message.
// Every third byte, or any byte flagged last, closes a group of up to three
// bytes, which yields exactly four characters with padding as needed.
// Closed groups wait in a two-entry queue between the byte front end and the
// character serializer, so the two sides stall independently.
// The first character of a group appears once the closed group has been written
// into the queue and then loaded into the serializer, when the serializer is free.
// The serializer emits one character per cycle while out_ready is high, so a
// steady stream yields four characters per three bytes, and bytes are accepted
// every cycle while the queue has room.
// When the receiver holds out_ready low, the current character holds; once the
// queue fills, in_ready falls until a group drains.
// Synchronous reset drops held bytes, queued groups and the pending character.
module base64_stream_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] char_code,
  output logic       last_char
);
  import b64e_pkg::*;

  logic          push;
  group_t        push_group;
  logic          pop;
  group_t        head;
  queue_status_t status;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .q_full     (status.full),
    .push       (push),
    .push_group (push_group)
  );

  b64e_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .head       (head),
    .status     (status)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .status    (status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .last_char (last_char)
  );

endmodule
